/* hw/rtl/fmsd_pkg.sv */
// Shared types and constants for the four-motor slew-limited drive tick block.
// Used by fmsd_slew, fmsd_div and four_motor_slew_drive_tick; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmsd_pkg;

    localparam int SPEED_W = 16;
    localparam int NUMER_W = 24;
    localparam int PERIOD_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 16'hFFFF;
    localparam logic [15:0] IDLE_COUNT_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_POSITION_MODE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLEW_STEP = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPEED_LIMIT = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CUTOFF_VOLTAGE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDLE_LIMIT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_RETARGET_THRESHOLD = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD_NUMERATOR = 3'd6;

    // Register values after reset.
    localparam logic [7:0] RST_SLEW_STEP = 8'd20;
    localparam logic [14:0] RST_SPEED_LIMIT = 15'd1000;
    localparam logic [15:0] RST_CUTOFF_VOLTAGE = 16'd1110;
    localparam logic [15:0] RST_IDLE_LIMIT = 16'd200;
    localparam logic [15:0] RST_RETARGET_THRESHOLD = 16'd5;
    localparam logic [23:0] RST_PERIOD_NUMERATOR = 24'd1000000;

    typedef struct packed {
        logic signed [15:0] speed_cmd_a;
        logic signed [15:0] speed_cmd_b;
        logic signed [15:0] speed_cmd_c;
        logic signed [15:0] speed_cmd_d;
        logic [15:0]        battery_voltage;
    } in_item_t;

    typedef struct packed {
        logic [15:0] period_a;
        logic [15:0] period_b;
        logic [15:0] period_c;
        logic [15:0] period_d;
        logic [3:0]  direction_bits;
        logic        drive_enable;
        logic        low_battery;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLEW,
        ST_FINAL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* hw/rtl/four_motor_slew_drive_tick.sv */
// Slew-rate-limited drive tick for MOTOR_COUNT stepper motors.
// Each tick slews every motor in turn, then sets direction and enable, then divides for the step
// period of up to four motors one after another; a low-battery tick skips straight to the divides.
// One transaction in work at a time; the next is taken once the result is registered, and a
// held-off m_ready on a pending result stalls the input.
// Reset (aresetn, synchronous) zeroes speeds, previous targets and idle state, loads defaults.
`timescale 1ns / 1ps
`default_nettype none

module four_motor_slew_drive_tick
    import fmsd_pkg::*;
#(
    parameter int MOTOR_COUNT = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
    localparam int CNT_W = $clog2(MOTOR_COUNT) + 1;
    localparam int DIV_MOTORS = (MOTOR_COUNT < 4) ? MOTOR_COUNT : 4;
    localparam int PIDX_W = (DIV_MOTORS > 1) ? $clog2(DIV_MOTORS) : 1;

    // Configuration registers.
    logic        position_mode_reg;
    logic [7:0]  slew_step_reg;
    logic [14:0] speed_limit_reg;
    logic [15:0] cutoff_voltage_reg;
    logic [15:0] idle_limit_reg;
    logic [15:0] retarget_threshold_reg;
    logic [23:0] period_numerator_reg;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [SPEED_W-1:0] speed_reg [MOTOR_COUNT];
    logic signed [SPEED_W-1:0] speed_next [MOTOR_COUNT];
    logic signed [SPEED_W-1:0] prev_reg [MOTOR_COUNT];
    logic signed [SPEED_W-1:0] prev_next [MOTOR_COUNT];
    logic signed [SPEED_W-1:0] tgt_reg [MOTOR_COUNT];
    logic [PERIOD_W-1:0]       period_reg [DIV_MOTORS];
    logic [PERIOD_W-1:0]       period_next [DIV_MOTORS];
    logic [15:0]               idle_count_reg, idle_count_next;
    logic                      auto_dis_reg, auto_dis_next;
    logic                      low_reg, low_next;
    logic                      idle_acc_reg, idle_acc_next;
    logic                      wake_acc_reg, wake_acc_next;
    logic                      enable_reg, enable_next;
    logic [3:0]                dir_reg, dir_next;
    logic                      m_valid_reg, m_valid_next;
    out_item_t                 m_data_reg, m_data_next;

    logic signed [SPEED_W-1:0] in_tgt [4];
    logic signed [SPEED_W-1:0] cur_speed;
    logic signed [SPEED_W-1:0] cur_tgt;
    logic signed [SPEED_W-1:0] cur_prev;
    logic signed [SPEED_W-1:0] slew_speed;
    logic signed [SPEED_W:0]   tgt_delta;
    logic [SPEED_W:0]          tgt_jump;
    logic [SPEED_W-1:0]        speed_mag;
    logic [3:0]                dir_now;
    logic [PERIOD_W-1:0]       out_period [4];
    logic                      accept;
    logic                      div_start;
    logic                      div_done;
    logic [PERIOD_W-1:0]       div_quotient;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    assign in_tgt[0] = s_data.speed_cmd_a;
    assign in_tgt[1] = s_data.speed_cmd_b;
    assign in_tgt[2] = s_data.speed_cmd_c;
    assign in_tgt[3] = s_data.speed_cmd_d;

    assign cur_speed = speed_reg[cnt_reg[IDX_W-1:0]];
    assign cur_tgt   = tgt_reg[cnt_reg[IDX_W-1:0]];
    assign cur_prev  = prev_reg[cnt_reg[IDX_W-1:0]];
    assign speed_mag = cur_speed[SPEED_W-1] ? SPEED_W'(-cur_speed) : cur_speed;
    assign tgt_delta = {cur_prev[SPEED_W-1], cur_prev} - {cur_tgt[SPEED_W-1], cur_tgt};
    assign tgt_jump  = tgt_delta[SPEED_W] ? (SPEED_W + 1)'(-tgt_delta) : tgt_delta;

    fmsd_slew u_slew (
        .speed       (cur_speed),
        .target      (cur_tgt),
        .slew_step   (slew_step_reg),
        .speed_limit (speed_limit_reg),
        .speed_new   (slew_speed)
    );

    fmsd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (period_numerator_reg),
        .divisor   (speed_mag),
        .done      (div_done),
        .quotient  (div_quotient)
    );

    // Direction bits: motors A and B reverse sense relative to C and D.
    for (genvar g = 0; g < 4; g++) begin : g_out
        if (g < MOTOR_COUNT) begin : g_used
            if (g < 2) begin : g_ab
                assign dir_now[g] = (speed_reg[g] <= 0);
            end else begin : g_cd
                assign dir_now[g] = (speed_reg[g] > 0);
            end
            assign out_period[g] = period_reg[g];
        end else begin : g_unused
            assign dir_now[g]    = 1'b0;
            assign out_period[g] = PERIOD_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_mode_reg      <= 1'b0;
            slew_step_reg          <= RST_SLEW_STEP;
            speed_limit_reg        <= RST_SPEED_LIMIT;
            cutoff_voltage_reg     <= RST_CUTOFF_VOLTAGE;
            idle_limit_reg         <= RST_IDLE_LIMIT;
            retarget_threshold_reg <= RST_RETARGET_THRESHOLD;
            period_numerator_reg   <= RST_PERIOD_NUMERATOR;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_POSITION_MODE:      position_mode_reg <= cfg_wdata[0];
                CFG_SLEW_STEP:          slew_step_reg <= cfg_wdata[7:0];
                CFG_SPEED_LIMIT:        speed_limit_reg <= cfg_wdata[14:0];
                CFG_CUTOFF_VOLTAGE:     cutoff_voltage_reg <= cfg_wdata[15:0];
                CFG_IDLE_LIMIT:         idle_limit_reg <= cfg_wdata[15:0];
                CFG_RETARGET_THRESHOLD: retarget_threshold_reg <= cfg_wdata[15:0];
                CFG_PERIOD_NUMERATOR:   period_numerator_reg <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            idle_count_reg <= '0;
            auto_dis_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                speed_reg[i] <= '0;
                prev_reg[i]  <= '0;
            end
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idle_count_reg <= idle_count_next;
            auto_dis_reg   <= auto_dis_next;
            m_valid_reg    <= m_valid_next;
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                speed_reg[i] <= speed_next[i];
                prev_reg[i]  <= prev_next[i];
            end
        end
        low_reg      <= low_next;
        idle_acc_reg <= idle_acc_next;
        wake_acc_reg <= wake_acc_next;
        enable_reg   <= enable_next;
        dir_reg      <= dir_next;
        m_data_reg   <= m_data_next;
        for (int i = 0; i < DIV_MOTORS; i++) begin
            period_reg[i] <= period_next[i];
        end
        if (accept) begin
            // Motors past the fourth always steer toward zero.
            for (int i = 0; i < MOTOR_COUNT; i++) begin
                tgt_reg[i] <= (i < 4) ? in_tgt[i[1:0]] : '0;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        speed_next      = speed_reg;
        prev_next       = prev_reg;
        period_next     = period_reg;
        idle_count_next = idle_count_reg;
        auto_dis_next   = auto_dis_reg;
        low_next        = low_reg;
        idle_acc_next   = idle_acc_reg;
        wake_acc_next   = wake_acc_reg;
        enable_next     = enable_reg;
        dir_next        = dir_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        div_start       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    low_next      = s_data.battery_voltage < cutoff_voltage_reg;
                    idle_acc_next = 1'b1;
                    wake_acc_next = 1'b0;
                    enable_next   = 1'b0;
                    dir_next      = '0;
                    cnt_next      = '0;
                    // A low battery skips the slews and keeps all speeds, then refreshes periods.
                    state_next    = (s_data.battery_voltage < cutoff_voltage_reg) ?
                                    ST_DIV_START : ST_SLEW;
                end
            end
            ST_SLEW: begin
                speed_next[cnt_reg[IDX_W-1:0]] = slew_speed;
                prev_next[cnt_reg[IDX_W-1:0]]  = cur_tgt;
                if (position_mode_reg) begin
                    if (slew_speed != 0) idle_acc_next = 1'b0;
                    if (tgt_jump > {1'b0, retarget_threshold_reg}) wake_acc_next = 1'b1;
                end else if (cur_tgt != 0) begin
                    idle_acc_next = 1'b0;
                    wake_acc_next = 1'b1;
                end
                if (cnt_reg == CNT_W'(MOTOR_COUNT - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FINAL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINAL: begin
                dir_next = dir_now;
                if (!auto_dis_reg) begin
                    if (idle_acc_reg) begin
                        if (idle_count_reg != IDLE_COUNT_MAX) begin
                            idle_count_next = idle_count_reg + 1'b1;
                        end
                    end else begin
                        idle_count_next = '0;
                    end
                    if (idle_count_next > idle_limit_reg) begin
                        auto_dis_next   = 1'b1;
                        idle_count_next = '0;
                    end
                end
                // A wake-up on the disabling tick still keeps the drivers off for it.
                if (auto_dis_next) begin
                    enable_next = 1'b0;
                    if (wake_acc_reg) auto_dis_next = 1'b0;
                end else begin
                    enable_next = 1'b1;
                end
                state_next = ST_DIV_START;
            end
            ST_DIV_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    period_next[cnt_reg[PIDX_W-1:0]] = div_quotient;
                    if (cnt_reg == CNT_W'(DIV_MOTORS - 1)) begin
                        cnt_next   = '0;
                        state_next = ST_OUT;
                    end else begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.period_a        = out_period[0];
                    m_data_next.period_b        = out_period[1];
                    m_data_next.period_c        = out_period[2];
                    m_data_next.period_d        = out_period[3];
                    m_data_next.direction_bits  = dir_reg;
                    m_data_next.drive_enable    = enable_reg;
                    m_data_next.low_battery     = low_reg;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The block takes one transaction at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted while a transaction is in work");

    // A low-battery result never drives the motors.
    a_low_battery_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.low_battery) |->
            (m_data.direction_bits == 4'd0 && !m_data.drive_enable))
        else $error("drive active on a low-battery result");

    // Setting auto-disable always clears the idle counter, and it stays clear.
    a_idle_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        auto_dis_reg |-> (idle_count_reg == 16'd0))
        else $error("idle counter running while auto-disabled");

    // A new result is only loaded once the previous one has been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("pending result dropped");

endmodule

`default_nettype wire

/* hw/rtl/fmsd_slew.sv */
// Shared slew and clamp unit: moves one motor speed one step toward its target.
// Depends on fmsd_pkg for the speed width.
`timescale 1ns / 1ps
`default_nettype none

module fmsd_slew
    import fmsd_pkg::*;
(
    input  wire logic signed [SPEED_W-1:0] speed,
    input  wire logic signed [SPEED_W-1:0] target,
    input  wire logic [7:0]                slew_step,
    input  wire logic [14:0]               speed_limit,
    output logic signed [SPEED_W-1:0]      speed_new
);

    logic signed [SPEED_W:0] stepped;
    logic signed [SPEED_W:0] lim_pos;
    logic signed [SPEED_W:0] lim_neg;
    logic signed [SPEED_W:0] step_ext;

    always_comb begin
        step_ext = $signed({{(SPEED_W-7){1'b0}}, slew_step});
        lim_pos  = $signed({2'b00, speed_limit});
        lim_neg  = -lim_pos;
        if (target > speed) begin
            stepped = $signed({speed[SPEED_W-1], speed}) + step_ext;
        end else if (target < speed) begin
            stepped = $signed({speed[SPEED_W-1], speed}) - step_ext;
        end else begin
            stepped = $signed({speed[SPEED_W-1], speed});
        end
        if (stepped < lim_neg) begin
            stepped = lim_neg;
        end
        if (stepped > lim_pos) begin
            stepped = lim_pos;
        end
        speed_new = stepped[SPEED_W-1:0];
    end

endmodule

`default_nettype wire

/* hw/rtl/fmsd_div.sv */
// Radix-2 restoring divider for the step period, one quotient bit per cycle.
// Saturating and zero-divisor cases finish at once. Depends on fmsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmsd_div
    import fmsd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [NUMER_W-1:0]  numerator,
    input  wire logic [SPEED_W-1:0]  divisor,
    output logic                     done,
    output logic [PERIOD_W-1:0]      quotient
);

    localparam int STEP_W = $clog2(PERIOD_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SPEED_W-1:0]  rem_reg, rem_next;
    logic [PERIOD_W-1:0] quo_reg, quo_next;
    logic [SPEED_W-1:0]  dvs_reg, dvs_next;

    logic [SPEED_W:0]    trial;
    logic [SPEED_W:0]    trial_diff;
    logic                trial_ge;
    logic                saturate;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        trial      = {rem_reg, quo_reg[PERIOD_W-1]};
        trial_diff = trial - {1'b0, dvs_reg};
        trial_ge   = trial >= {1'b0, dvs_reg};
        // A quotient that needs more than 16 bits is clipped to the maximum period.
        saturate   = (divisor == '0) ||
                     ({{(SPEED_W + PERIOD_W - NUMER_W){1'b0}}, numerator} >=
                      {divisor, {PERIOD_W{1'b0}}});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start) begin
            dvs_next = divisor;
            if (saturate) begin
                quo_next  = PERIOD_MAX;
                done_next = 1'b1;
                busy_next = 1'b0;
            end else begin
                // The upper numerator bits are already below the divisor here.
                rem_next  = {{(SPEED_W + PERIOD_W - NUMER_W){1'b0}},
                             numerator[NUMER_W-1:PERIOD_W]};
                quo_next  = numerator[PERIOD_W-1:0];
                step_next = STEP_W'(PERIOD_W - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = trial_ge ? trial_diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
            quo_next = {quo_reg[PERIOD_W-2:0], trial_ge};
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
